// ===== design/camera_pixel_unpacker_macros.svh =====
// assertion macros for the camera pixel unpacker
`ifndef CAMERA_PIXEL_UNPACKER_MACROS_SVH
`define CAMERA_PIXEL_UNPACKER_MACROS_SVH

// same-cycle implication, checked outside reset
`define CPXU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define CPXU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/cpxu_pkg.sv =====
// shared types and constants for the camera pixel unpacker
package cpxu_pkg;

	localparam int PORT_WORD_W      = 16;
	localparam int PIXEL_W          = 6;
	localparam int FRAME_PIXELS_W   = 17;
	localparam int MAX_FRAME_PIXELS = 76800;
	localparam logic [FRAME_PIXELS_W-1:0] FRAME_PIXELS_RST = 17'd19200;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_SIX_BIT_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BIDIR_MODE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PIXELS = 2'd2;

	// result queue geometry
	localparam int FIFO_AW    = 2;
	localparam int FIFO_DEPTH = 1 << FIFO_AW;

	typedef struct packed {
		logic [PORT_WORD_W-1:0] port_word;
		logic                   start_of_frame;
	} word_beat_t;

	typedef struct packed {
		logic [PIXEL_W-1:0] pixel;
		logic               last_in_run;
		logic               end_of_frame;
	} pix_beat_t;

endpackage

// ===== design/camera_pixel_unpacker.sv =====
// top level of the camera pixel unpacker
//
//  channel  | signals                          | dir | beat
//  ---------+----------------------------------+-----+------------------------------
//  word     | word_valid word_stall word_beat  | in  | one raw port read
//  pix      | pix_valid pix_stall pix_beat     | out | one inverted grey pixel
//  cfg      | cfg_valid cfg_ready cfg_index    | in  | one register write
//           | cfg_data                         |     |
//
// one port read is taken per cycle while word_stall is low; a read that yields two pixels
// (bidirectional word, or the third byte of a 6-bit group) needs two pix beats, so the
// single-pixel output port, not the input, limits the rate of reads in those cases
// a read passes through the word input register, then the result queue register
// reset clears phases, pixel count, frame flag and the queue, and loads the register
// reset values; cfg_ready is always high
// word_stall rises when the input register holds a read and the result queue lacks
// room for two pixels; a stall on pix only fills the queue
module camera_pixel_unpacker
	import cpxu_pkg::*;
#(
	parameter int MaxFramePixels = MAX_FRAME_PIXELS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      word_valid,
	output logic                      word_stall,
	input  word_beat_t                word_beat,
	output logic                      pix_valid,
	input  logic                      pix_stall,
	output pix_beat_t                 pix_beat,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [FRAME_PIXELS_W-1:0] cfg_data
);

`include "camera_pixel_unpacker_macros.svh"

	// count width holds the largest frame; compare width covers count and register
	localparam int CNT_W = $clog2(MaxFramePixels + 1);
	localparam int CMP_W = (CNT_W > FRAME_PIXELS_W) ? CNT_W : FRAME_PIXELS_W;
	localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MaxFramePixels);
	localparam logic [FIFO_AW:0] ROOM_LIMIT = (FIFO_AW + 1)'(FIFO_DEPTH - 2);

	// configuration registers
	logic                      six_bit_mode_q;
	logic                      bidir_mode_q;
	logic [FRAME_PIXELS_W-1:0] frame_pixels_q;

	// decode state
	logic             nibble_phase_q;
	logic [1:0]       byte_phase_q;
	logic [3:0]       held_nibble_q;
	logic [3:0]       carry_bits_q;
	logic [CNT_W-1:0] pixel_count_q;
	logic             frame_done_q;

	// input register
	logic       valid_s1;
	word_beat_t beat_s1;

	// result queue
	pix_beat_t        fifo_mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] head_q;
	logic [FIFO_AW-1:0] tail_q;
	logic [FIFO_AW:0]   fifo_cnt_q;

	logic room;
	logic adv;
	logic pop;

	// frame size after clamping to 1..max
	logic [CMP_W-1:0] fp_ext;
	logic [CNT_W-1:0] frame_size;

	// decode results
	logic             sof;
	logic [3:0]       nib;
	logic [7:0]       byte_val;
	logic             eff_nph;
	logic [1:0]       eff_bph;
	logic [3:0]       eff_held;
	logic [3:0]       eff_carry;
	logic [CNT_W-1:0] eff_cnt;
	logic             eff_done;

	logic             nph_d;
	logic [1:0]       bph_d;
	logic [3:0]       held_d;
	logic [3:0]       carry_d;
	logic [1:0]       n_cand;
	logic [PIXEL_W-1:0] v0;
	logic [PIXEL_W-1:0] v1;

	logic             e0;
	logic             e1;
	logic [CNT_W-1:0] cnt0;
	logic [CNT_W-1:0] cnt1;
	logic             eof0;
	logic             eof1;
	logic [CNT_W-1:0] cnt_d;
	logic             done_d;
	pix_beat_t        r0;
	pix_beat_t        r1;
	logic [FIFO_AW:0] push_n;

	assign cfg_ready = 1'b1;

	// queue handshake
	assign room       = (fifo_cnt_q <= ROOM_LIMIT);
	assign adv        = valid_s1 && room;
	assign word_stall = valid_s1 && !room;
	assign pix_valid  = (fifo_cnt_q != '0);
	assign pix_beat   = fifo_mem_q[head_q];
	assign pop        = pix_valid && !pix_stall;

	// clamp frame size
	always_comb begin
		fp_ext = CMP_W'(frame_pixels_q);
		if (fp_ext == '0) begin
			frame_size = CNT_W'(1);
		end else if (fp_ext > MAX_CMP) begin
			frame_size = CNT_W'(MaxFramePixels);
		end else begin
			frame_size = fp_ext[CNT_W-1:0];
		end
	end

	// decode one read: candidate pixels and next phases
	always_comb begin
		sof       = beat_s1.start_of_frame;
		nib       = beat_s1.port_word[7:4];
		eff_nph   = sof ? 1'b0 : nibble_phase_q;
		eff_bph   = sof ? 2'd0 : byte_phase_q;
		eff_held  = sof ? 4'd0 : held_nibble_q;
		eff_carry = sof ? 4'd0 : carry_bits_q;
		eff_cnt   = sof ? '0 : pixel_count_q;
		eff_done  = sof ? 1'b0 : frame_done_q;
		byte_val  = {eff_held, nib};

		nph_d   = eff_nph;
		bph_d   = eff_bph;
		held_d  = eff_held;
		carry_d = eff_carry;
		n_cand  = 2'd0;
		v0      = '0;
		v1      = '0;

		case ({bidir_mode_q, six_bit_mode_q})
			2'b11: begin
				// word read: two pixels from scattered bits
				n_cand = 2'd2;
				v0     = ~beat_s1.port_word[6:1];
				v1     = ~{beat_s1.port_word[15:11], beat_s1.port_word[7]};
			end
			2'b00: begin
				n_cand = 2'd1;
				v0     = {2'b00, ~nib};
			end
			2'b01: begin
				if (!eff_nph) begin
					held_d = nib;
					nph_d  = 1'b1;
				end else begin
					nph_d = 1'b0;
					case (eff_bph)
						2'd0: begin
							n_cand  = 2'd1;
							v0      = ~byte_val[7:2];
							carry_d = {2'b00, byte_val[1:0]};
							bph_d   = 2'd1;
						end
						2'd1: begin
							n_cand  = 2'd1;
							v0      = ~{eff_carry[1:0], byte_val[7:4]};
							carry_d = byte_val[3:0];
							bph_d   = 2'd2;
						end
						default: begin
							// byte phase two, and the unreachable phase three
							n_cand  = 2'd2;
							v0      = ~{eff_carry, byte_val[7:6]};
							v1      = ~byte_val[5:0];
							carry_d = 4'd0;
							bph_d   = 2'd0;
						end
					endcase
				end
			end
			default: begin
				// bidirectional 4-bit: unsupported, nothing moves
			end
		endcase
	end

	// pixel counting and frame end
	always_comb begin
		e0   = (n_cand != 2'd0) && !eff_done;
		cnt0 = eff_cnt + CNT_W'(1);
		eof0 = (cnt0 >= frame_size);
		e1   = (n_cand == 2'd2) && e0 && !eof0;
		cnt1 = cnt0 + CNT_W'(1);
		eof1 = (cnt1 >= frame_size);

		cnt_d  = eff_cnt;
		done_d = eff_done;
		if (e1) begin
			cnt_d  = cnt1;
			done_d = eof1;
		end else if (e0) begin
			cnt_d  = cnt0;
			done_d = eof0;
		end

		r0.pixel        = v0;
		r0.last_in_run  = !e1;
		r0.end_of_frame = eof0;
		r1.pixel        = v1;
		r1.last_in_run  = 1'b1;
		r1.end_of_frame = eof1;

		push_n = '0;
		if (adv) begin
			push_n = (FIFO_AW + 1)'(e0) + (FIFO_AW + 1)'(e1);
		end
	end

	// configuration writes; unknown index is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			six_bit_mode_q <= 1'b1;
			bidir_mode_q   <= 1'b0;
			frame_pixels_q <= FRAME_PIXELS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SIX_BIT_MODE: six_bit_mode_q <= cfg_data[0];
				CFG_BIDIR_MODE:   bidir_mode_q   <= cfg_data[0];
				CFG_FRAME_PIXELS: frame_pixels_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || adv) begin
			valid_s1 <= word_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (word_valid && !word_stall) begin
			beat_s1 <= word_beat;
		end
	end

	// decode state advances as the read leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nibble_phase_q <= 1'b0;
			byte_phase_q   <= 2'd0;
			held_nibble_q  <= 4'd0;
			carry_bits_q   <= 4'd0;
			pixel_count_q  <= '0;
			frame_done_q   <= 1'b0;
		end else if (adv) begin
			nibble_phase_q <= nph_d;
			byte_phase_q   <= bph_d;
			held_nibble_q  <= held_d;
			carry_bits_q   <= carry_d;
			pixel_count_q  <= cnt_d;
			frame_done_q   <= done_d;
		end
	end

	// result queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			tail_q     <= '0;
			fifo_cnt_q <= '0;
		end else begin
			if (pop) begin
				head_q <= head_q + FIFO_AW'(1);
			end
			tail_q     <= tail_q + push_n[FIFO_AW-1:0];
			fifo_cnt_q <= fifo_cnt_q + push_n - (FIFO_AW + 1)'(pop);
		end
	end

	// result queue storage
	always_ff @(posedge clk) begin
		if (adv && e0) begin
			fifo_mem_q[tail_q] <= r0;
		end
		if (adv && e1) begin
			fifo_mem_q[tail_q + FIFO_AW'(1)] <= r1;
		end
	end

	`CPXU_ASSERT_NOW(a_fifo_bound, 1'b1, fifo_cnt_q <= (FIFO_AW + 1)'(FIFO_DEPTH), "result queue overflow")
	`CPXU_ASSERT_NOW(a_done_drops, adv && frame_done_q && !beat_s1.start_of_frame, push_n == '0, "pixel pushed after end of frame")
	`CPXU_ASSERT_NEXT(a_eof_sets_done, adv && ((e0 && eof0) || (e1 && eof1)), frame_done_q, "frame flag not set after last pixel")

endmodule
